/* rtl/otp_pkg.sv */
`default_nettype none

package otp_pkg;

   // channel bank limits and defaults
   localparam int CHANNELS_DEF       = 12;
   localparam int INVERTER_INDEX_DEF = 9;
   localparam int STEERING_INDEX_DEF = 3;
   localparam int MAX_CHANNELS       = 16;
   localparam int MASK_W             = 12;

   // field widths
   localparam int CHAN_W    = 4;
   localparam int CUR_W     = 16;
   localparam int TIME_W    = 32;
   localparam int PCT_W     = 9;
   localparam int NOM_W     = 16;
   localparam int INRUSH_W  = 4;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 32;

   // scaled compare widths: current * 100 and nominal * percent
   localparam int C100_W    = 23;
   localparam int TH_W      = 25;
   localparam int PCT_SCALE = 100;

   // register reset values
   localparam logic [PCT_W-1:0]    WARN_PCT_RST    = 9'd110;
   localparam logic [PCT_W-1:0]    TIMER_PCT_RST   = 9'd140;
   localparam logic [PCT_W-1:0]    INSTANT_PCT_RST = 9'd170;
   localparam logic [TIME_W-1:0]   TIMEOUT_RST     = 32'd60000;
   localparam logic [NOM_W-1:0]    NOM_DEF_RST     = 16'd2000;
   localparam logic [NOM_W-1:0]    NOM_INV_RST     = 16'd2500;
   localparam logic [NOM_W-1:0]    NOM_STR_RST     = 16'd3000;
   localparam logic [INRUSH_W-1:0] INRUSH_RST      = 4'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WARN_PCT    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TIMER_PCT   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INSTANT_PCT = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT     = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NOM_DEF     = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_NOM_INV     = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_NOM_STR     = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_INRUSH      = 4'd7;

   typedef enum logic [2:0] {
      LVL_NORMAL  = 3'd0,
      LVL_WARNING = 3'd1,
      LVL_TIMER   = 3'd2,
      LVL_INSTANT = 3'd3,
      LVL_TIMED   = 3'd4
   } level_type;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_WARNING = 2'd1,
      KIND_TIMER   = 2'd2,
      KIND_TRIP    = 2'd3
   } kind_type;

   typedef logic [MAX_CHANNELS-1:0] chvec_type;

   // configuration register bank
   typedef struct packed {
      logic [PCT_W-1:0]    warn_pct;
      logic [PCT_W-1:0]    timer_pct;
      logic [PCT_W-1:0]    instant_pct;
      logic [TIME_W-1:0]   timeout_ms;
      logic [NOM_W-1:0]    nom_def_ma;
      logic [NOM_W-1:0]    nom_inv_ma;
      logic [NOM_W-1:0]    nom_str_ma;
      logic [INRUSH_W-1:0] inrush_samples;
   } cfg_type;

   // item held in the input register, with scaled current and thresholds
   typedef struct packed {
      logic [CHAN_W-1:0] chan;
      logic              in_range;
      logic              is_inv;
      logic              is_str;
      logic [C100_W-1:0] c100;
      logic [TH_W-1:0]   th_inst;
      logic [TH_W-1:0]   th_timer;
      logic [TH_W-1:0]   th_warn;
      logic [TIME_W-1:0] time_ms;
      logic              on;
      logic              locked;
   } stage_type;

   // result item
   typedef struct packed {
      level_type         level;
      logic              trip;
      kind_type          kind;
      logic [CHAN_W-1:0] rpt_chan;
      logic [MASK_W-1:0] warn_mask;
      logic [MASK_W-1:0] timer_mask;
      logic [TIME_W-1:0] elapsed;
   } result_type;

endpackage

`default_nettype wire

/* rtl/otp_csr.sv */
`default_nettype none

module otp_csr
   import otp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_WARN_PCT:    cfg_in.warn_pct       = csr_data[PCT_W-1:0];
            REG_TIMER_PCT:   cfg_in.timer_pct      = csr_data[PCT_W-1:0];
            REG_INSTANT_PCT: cfg_in.instant_pct    = csr_data[PCT_W-1:0];
            REG_TIMEOUT:     cfg_in.timeout_ms     = csr_data[TIME_W-1:0];
            REG_NOM_DEF:     cfg_in.nom_def_ma     = csr_data[NOM_W-1:0];
            REG_NOM_INV:     cfg_in.nom_inv_ma     = csr_data[NOM_W-1:0];
            REG_NOM_STR:     cfg_in.nom_str_ma     = csr_data[NOM_W-1:0];
            REG_INRUSH:      cfg_in.inrush_samples = csr_data[INRUSH_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.warn_pct       <= WARN_PCT_RST;
         cfg_ff.timer_pct      <= TIMER_PCT_RST;
         cfg_ff.instant_pct    <= INSTANT_PCT_RST;
         cfg_ff.timeout_ms     <= TIMEOUT_RST;
         cfg_ff.nom_def_ma     <= NOM_DEF_RST;
         cfg_ff.nom_inv_ma     <= NOM_INV_RST;
         cfg_ff.nom_str_ma     <= NOM_STR_RST;
         cfg_ff.inrush_samples <= INRUSH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/otp_scale.sv */
`default_nettype none

module otp_scale
   import otp_pkg::*;
#(
   parameter int CHANNELS       = CHANNELS_DEF,
   parameter int INVERTER_INDEX = INVERTER_INDEX_DEF,
   parameter int STEERING_INDEX = STEERING_INDEX_DEF
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [CHAN_W-1:0] in_chan,
   input  wire logic [CUR_W-1:0]  in_cur,
   input  wire logic [TIME_W-1:0] in_time,
   input  wire logic              in_on,
   input  wire logic              in_locked,
   output logic                   stage_valid,
   input  wire logic              stage_take,
   output stage_type              stage
);

   logic      valid_ff;
   logic      valid_in;
   stage_type stage_ff;
   stage_type stage_in;
   logic      accept;
   logic [NOM_W-1:0] nom;

   assign in_ready    = !valid_ff || stage_take;
   assign accept      = in_valid && in_ready;
   assign stage_valid = valid_ff;
   assign stage       = stage_ff;

   // channel role and nominal current
   always_comb begin
      stage_in.chan     = in_chan;
      stage_in.in_range = {1'b0, in_chan} < (CHAN_W + 1)'(CHANNELS);
      stage_in.is_inv   = in_chan == CHAN_W'(INVERTER_INDEX);
      stage_in.is_str   = !stage_in.is_inv && (in_chan == CHAN_W'(STEERING_INDEX));
      if (stage_in.is_inv) begin
         nom = cfg.nom_inv_ma;
      end else if (stage_in.is_str) begin
         nom = cfg.nom_str_ma;
      end else begin
         nom = cfg.nom_def_ma;
      end
      // scaled current and the three thresholds, compared without division
      stage_in.c100     = C100_W'(in_cur) * C100_W'(PCT_SCALE);
      stage_in.th_inst  = TH_W'(nom) * TH_W'(cfg.instant_pct);
      stage_in.th_timer = TH_W'(nom) * TH_W'(cfg.timer_pct);
      stage_in.th_warn  = TH_W'(nom) * TH_W'(cfg.warn_pct);
      stage_in.time_ms  = in_time;
      stage_in.on       = in_on;
      stage_in.locked   = in_locked;
   end

   // input register occupancy
   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (stage_take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/otp_tier.sv */
`default_nettype none

module otp_tier
   import otp_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
)
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      stage_valid,
   output logic           stage_take,
   input  wire stage_type stage,
   output logic           out_valid,
   input  wire logic      out_ready,
   output result_type     out_result
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // per-channel protection state and per-role inrush counters
   logic [CHANNELS-1:0] run_ff;
   logic [CHANNELS-1:0] run_in;
   logic [CHANNELS-1:0] warn_ff;
   logic [CHANNELS-1:0] warn_in;
   logic [TIME_W-1:0]   start_ff [CHANNELS];
   logic [TIME_W-1:0]   start_in [CHANNELS];
   logic [INRUSH_W-1:0] inr_ff [2];
   logic [INRUSH_W-1:0] inr_in [2];

   logic                out_valid_ff;
   logic                out_valid_in;
   result_type          result_ff;
   result_type          result_in;

   logic [IDX_W-1:0]    idx;
   logic                load;
   logic                role;
   logic                role_sel;
   logic                run_cur;
   logic [TIME_W-1:0]   start_cur;
   logic [TIME_W-1:0]   start_eff;
   logic [TIME_W-1:0]   diff;
   logic [INRUSH_W-1:0] inr_cur;
   logic [INRUSH_W-1:0] inr_inc;
   logic                above_inst;
   logic                above_timer;
   logic                above_warn;
   logic                timed;
   logic                inr_trip;
   chvec_type           run_pad;
   chvec_type           warn_pad;

   assign stage_take = !out_valid_ff || out_ready;
   assign load       = stage_valid && stage_take;
   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

   // tier compares and current channel state
   assign idx         = stage.chan[IDX_W-1:0];
   assign role        = stage.is_inv || stage.is_str;
   assign role_sel    = stage.is_str;
   assign run_cur     = run_ff[idx];
   assign start_cur   = start_ff[idx];
   assign above_inst  = TH_W'(stage.c100) > stage.th_inst;
   assign above_timer = TH_W'(stage.c100) >= stage.th_timer;
   assign above_warn  = TH_W'(stage.c100) > stage.th_warn;
   assign timed       = above_timer || (above_warn && run_cur);
   assign start_eff   = run_cur ? start_cur : stage.time_ms;
   assign diff        = stage.time_ms - start_eff;
   assign inr_cur     = inr_ff[role_sel];
   assign inr_inc     = (inr_cur == {INRUSH_W{1'b1}}) ? inr_cur : inr_cur + INRUSH_W'(1);
   assign inr_trip    = !role || (inr_inc >= cfg.inrush_samples);

   // decision and next state
   always_comb begin
      run_in   = run_ff;
      warn_in  = warn_ff;
      start_in = start_ff;
      inr_in   = inr_ff;
      result_in.level    = LVL_NORMAL;
      result_in.trip     = 1'b0;
      result_in.kind     = KIND_NONE;
      result_in.rpt_chan = '0;
      result_in.elapsed  = '0;
      if (stage.in_range) begin
         if (!stage.on || stage.locked) begin
            run_in[idx]  = 1'b0;
            warn_in[idx] = 1'b0;
         end else if (above_inst) begin
            if (role) begin
               inr_in[role_sel] = inr_trip ? '0 : inr_inc;
            end
            if (inr_trip) begin
               run_in[idx]     = 1'b0;
               warn_in[idx]    = 1'b0;
               result_in.level = LVL_INSTANT;
               result_in.trip  = 1'b1;
               result_in.kind  = KIND_TRIP;
            end else begin
               warn_in[idx]    = 1'b1;
               result_in.level = LVL_WARNING;
            end
         end else begin
            if (role) begin
               inr_in[role_sel] = '0;
            end
            if (timed) begin
               warn_in[idx]  = 1'b1;
               run_in[idx]   = 1'b1;
               start_in[idx] = start_eff;
               if (!run_cur) begin
                  result_in.kind = KIND_TIMER;
               end
               if (diff >= cfg.timeout_ms) begin
                  run_in[idx]     = 1'b0;
                  warn_in[idx]    = 1'b0;
                  result_in.level = LVL_TIMED;
                  result_in.trip  = 1'b1;
                  result_in.kind  = KIND_TRIP;
               end else begin
                  result_in.level = LVL_TIMER;
               end
            end else if (above_warn) begin
               warn_in[idx]    = 1'b1;
               result_in.level = LVL_WARNING;
               result_in.kind  = KIND_WARNING;
            end else begin
               run_in[idx]  = 1'b0;
               warn_in[idx] = 1'b0;
            end
         end
         if (run_in[idx]) begin
            result_in.elapsed = diff;
         end
         if (result_in.kind != KIND_NONE || result_in.trip) begin
            result_in.rpt_chan = stage.chan;
         end
      end
      run_pad  = chvec_type'(run_in);
      warn_pad = chvec_type'(warn_in);
      result_in.warn_mask  = warn_pad[MASK_W-1:0];
      result_in.timer_mask = run_pad[MASK_W-1:0];
   end

   // result register occupancy
   always_comb begin
      if (load) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         run_ff       <= '0;
         warn_ff      <= '0;
         inr_ff[0]    <= '0;
         inr_ff[1]    <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (load) begin
            run_ff  <= run_in;
            warn_ff <= warn_in;
            inr_ff  <= inr_in;
         end
      end
   end

   // start times only matter while the timer runs, the result only while out_valid is set
   always_ff @(posedge clock) begin
      if (load) begin
         start_ff <= start_in;
         result_ff <= result_in;
      end
   end

`ifndef SYNTHESIS
   // a running timer always carries its warning flag
   a_timer_has_warning: assert property (@(posedge clock) disable iff (reset)
      (run_ff & ~warn_ff) == '0)
      else $error("timer running without warning flag");

   // a trip leaves its channel with no timer and no warning
   a_trip_clears: assert property (@(posedge clock) disable iff (reset)
      (load && stage.in_range && result_in.trip) |=>
         (!run_ff[$past(idx)] && !warn_ff[$past(idx)]))
      else $error("tripped channel still flagged");

   // state moves only with an item
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !load |=> ($stable(run_ff) && $stable(warn_ff)))
      else $error("channel state changed without an item");

   // a normal level never carries a report
   a_normal_quiet: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.level == LVL_NORMAL) |->
         (result_ff.kind == KIND_NONE && !result_ff.trip))
      else $error("report on a normal level");
`endif

endmodule

`default_nettype wire

/* rtl/tiered_overcurrent_protection_core.sv */
`default_nettype none

// Tiered overcurrent protection for a bank of load channels.
// req_ carries one current sample per item: the channel index in req_tuser and
// the current, millisecond timestamp and switch status in req_tdata. rsp_ returns
// one item per sample: protection level, trip command, report kind (rsp_tuser),
// report channel, warning and timer masks and the running timer's elapsed time.
// csr_ writes the thresholds, nominal currents, timeout and inrush count; it is
// always ready and should only be written while no item is in flight.
// Current and thresholds are scaled by the multipliers on the way into the input
// register; the tier compare then updates channel state and loads the result
// register, which drives rsp_tvalid. Throughput is one item per cycle while
// rsp_tready stays high.
// Reset restores the register defaults, clears all warning, timer and inrush
// state and empties both pipeline registers.
// When rsp_tready is low the result is held; one more item is taken into the
// input register and req_tready then drops until the result is taken.
module tiered_overcurrent_protection_core
   import otp_pkg::*;
#(
   parameter int CHANNELS       = CHANNELS_DEF,
   parameter int INVERTER_INDEX = INVERTER_INDEX_DEF,
   parameter int STEERING_INDEX = STEERING_INDEX_DEF
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // current[15:0], time_ms[47:16], channel_on[48], channel_locked[49], zero[55:50]
   input  wire logic [55:0]          req_tdata,
   // channel[3:0]
   input  wire logic [CHAN_W-1:0]    req_tuser,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // level[2:0], trip[3], report_channel[7:4], warning_mask[19:8],
   // timer_mask[31:20], timer_elapsed_ms[63:32]
   output logic [63:0]               rsp_tdata,
   // report_kind[1:0]
   output logic [1:0]                rsp_tuser,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data
);

   cfg_type    cfg;
   stage_type  stage;
   logic       stage_valid;
   logic       stage_take;
   result_type result;

   otp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   otp_scale #(
      .CHANNELS       (CHANNELS),
      .INVERTER_INDEX (INVERTER_INDEX),
      .STEERING_INDEX (STEERING_INDEX)
   ) u_scale (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_chan     (req_tuser),
      .in_cur      (req_tdata[15:0]),
      .in_time     (req_tdata[47:16]),
      .in_on       (req_tdata[48]),
      .in_locked   (req_tdata[49]),
      .stage_valid (stage_valid),
      .stage_take  (stage_take),
      .stage       (stage)
   );

   otp_tier #(
      .CHANNELS (CHANNELS)
   ) u_tier (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .stage_valid (stage_valid),
      .stage_take  (stage_take),
      .stage       (stage),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_result  (result)
   );

   // result packing
   assign rsp_tdata = {result.elapsed, result.timer_mask, result.warn_mask,
                       result.rpt_chan, result.trip, result.level};
   assign rsp_tuser = result.kind;

endmodule

`default_nettype wire

/* bench/tiered_overcurrent_protection_core_tb.sv */
`timescale 1ns / 100ps

import otp_pkg::*;

// tracks channel protection state and holds the responses each sample must produce
class protection_tracker;
   cfg_type    cfg;
   bit         timer_run [MAX_CHANNELS];
   bit [31:0]  timer_t0 [MAX_CHANNELS];
   bit         warn_flag [MAX_CHANNELS];
   bit [3:0]   inrush_cnt [2];
   result_type verdicts [$];
   int         mismatches;
   int         responses;

   function new();
      int i;
      cfg.warn_pct       = WARN_PCT_RST;
      cfg.timer_pct      = TIMER_PCT_RST;
      cfg.instant_pct    = INSTANT_PCT_RST;
      cfg.timeout_ms     = TIMEOUT_RST;
      cfg.nom_def_ma     = NOM_DEF_RST;
      cfg.nom_inv_ma     = NOM_INV_RST;
      cfg.nom_str_ma     = NOM_STR_RST;
      cfg.inrush_samples = INRUSH_RST;
      for (i = 0; i < MAX_CHANNELS; i++) drop_channel(i);
      inrush_cnt[0] = '0;
      inrush_cnt[1] = '0;
      mismatches = 0;
      responses  = 0;
   endfunction

   function void drop_channel(int ch);
      timer_run[ch] = 1'b0;
      timer_t0[ch]  = '0;
      warn_flag[ch] = 1'b0;
   endfunction

   function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      case (idx)
         REG_WARN_PCT:    cfg.warn_pct       = val[PCT_W-1:0];
         REG_TIMER_PCT:   cfg.timer_pct      = val[PCT_W-1:0];
         REG_INSTANT_PCT: cfg.instant_pct    = val[PCT_W-1:0];
         REG_TIMEOUT:     cfg.timeout_ms     = val[TIME_W-1:0];
         REG_NOM_DEF:     cfg.nom_def_ma     = val[NOM_W-1:0];
         REG_NOM_INV:     cfg.nom_inv_ma     = val[NOM_W-1:0];
         REG_NOM_STR:     cfg.nom_str_ma     = val[NOM_W-1:0];
         REG_INRUSH:      cfg.inrush_samples = val[INRUSH_W-1:0];
         default: ;
      endcase
   endfunction

   // tier decision for one accepted sample
   function void note_sample(logic [3:0] chan, logic [15:0] cur, logic [31:0] now,
                             logic on, logic locked);
      result_type r;
      bit [63:0]  c100;
      bit [63:0]  nom;
      bit [31:0]  since;
      int         role;
      bit         fire;
      int         i;
      r       = '0;
      r.level = LVL_NORMAL;
      r.kind  = KIND_NONE;
      if (chan < CHANNELS_DEF) begin
         role = -1;
         nom  = 64'(cfg.nom_def_ma);
         // inverter takes priority over steering
         if (chan == INVERTER_INDEX_DEF) begin
            role = 0;
            nom  = 64'(cfg.nom_inv_ma);
         end else if (chan == STEERING_INDEX_DEF) begin
            role = 1;
            nom  = 64'(cfg.nom_str_ma);
         end
         c100 = 64'(cur) * 64'(PCT_SCALE);
         if (!on || locked) begin
            drop_channel(chan);
         end else if (c100 > nom * 64'(cfg.instant_pct)) begin
            fire = 1'b1;
            if (role >= 0) begin
               if (inrush_cnt[role] != 4'd15) inrush_cnt[role] = inrush_cnt[role] + 4'd1;
               fire = (inrush_cnt[role] >= cfg.inrush_samples);
            end
            if (fire) begin
               drop_channel(chan);
               if (role >= 0) inrush_cnt[role] = '0;
               r.level = LVL_INSTANT;
               r.trip  = 1'b1;
               r.kind  = KIND_TRIP;
            end else begin
               // inrush still pending
               warn_flag[chan] = 1'b1;
               r.level = LVL_WARNING;
            end
         end else begin
            if (role >= 0) inrush_cnt[role] = '0;
            if (c100 >= nom * 64'(cfg.timer_pct) ||
                (c100 > nom * 64'(cfg.warn_pct) && timer_run[chan])) begin
               warn_flag[chan] = 1'b1;
               if (!timer_run[chan]) begin
                  timer_run[chan] = 1'b1;
                  timer_t0[chan]  = now;
                  r.kind = KIND_TIMER;
               end
               since = now - timer_t0[chan];
               if (since >= cfg.timeout_ms) begin
                  drop_channel(chan);
                  r.level = LVL_TIMED;
                  r.trip  = 1'b1;
                  r.kind  = KIND_TRIP;
               end else begin
                  r.level = LVL_TIMER;
               end
            end else if (c100 > nom * 64'(cfg.warn_pct)) begin
               warn_flag[chan] = 1'b1;
               r.level = LVL_WARNING;
               r.kind  = KIND_WARNING;
            end else begin
               drop_channel(chan);
            end
         end
         if (timer_run[chan]) r.elapsed = now - timer_t0[chan];
      end
      for (i = 0; i < MASK_W && i < CHANNELS_DEF; i++) begin
         r.warn_mask[i]  = warn_flag[i];
         r.timer_mask[i] = timer_run[i];
      end
      r.rpt_chan = (r.kind != KIND_NONE || r.trip) ? chan : '0;
      verdicts.push_back(r);
   endfunction

   task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      if (mismatches < 100)
         $display("mismatch in response %0d: %s is %0h, expected %0h",
                  responses, field, got, want);
      mismatches++;
   endtask

   // compare one response item with the oldest outstanding verdict
   task check_response(logic [63:0] data, logic [1:0] user);
      result_type want;
      if (verdicts.size() == 0) begin
         report_mismatch("unexpected response", data[31:0], '0);
      end else begin
         want = verdicts.pop_front();
         if (data[2:0] !== want.level)
            report_mismatch("level", 32'(data[2:0]), 32'(want.level));
         if (data[3] !== want.trip)
            report_mismatch("trip", 32'(data[3]), 32'(want.trip));
         if (user !== want.kind)
            report_mismatch("report_kind", 32'(user), 32'(want.kind));
         if (data[7:4] !== want.rpt_chan)
            report_mismatch("report_channel", 32'(data[7:4]), 32'(want.rpt_chan));
         if (data[19:8] !== want.warn_mask)
            report_mismatch("warning_mask", 32'(data[19:8]), 32'(want.warn_mask));
         if (data[31:20] !== want.timer_mask)
            report_mismatch("timer_mask", 32'(data[31:20]), 32'(want.timer_mask));
         if (data[63:32] !== want.elapsed)
            report_mismatch("timer_elapsed_ms", data[63:32], want.elapsed);
      end
      responses++;
   endtask

   function int pending();
      return verdicts.size();
   endfunction
endclass

module tiered_overcurrent_protection_core_tb;

   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_AT     = 300;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 110;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [55:0]          req_tdata;
   logic [CHAN_W-1:0]    req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [63:0]          rsp_tdata;
   logic [1:0]           rsp_tuser;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;

   protection_tracker board = new();

   int          idle_cycles = 0;
   int          sent_total = 0;
   bit          send_burst = 1'b0;
   logic [31:0] ms_now = '0;

   tiered_overcurrent_protection_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // stall watchdog: cycles without any accepted item
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles = idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tiered_overcurrent_protection_core test failed");
         $finish;
      end
   end

   // response side with random back-pressure and one long hold-off
   initial begin
      int gap;
      int taken;
      bit burst;
      taken = 0;
      burst = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         if (taken % 40 == 0) burst = ($urandom_range(0, 2) == 0);
         gap = burst ? 0 : $urandom_range(0, 12);
         if (taken == HOLD_AT) gap = HOLD_CYCLES;
         repeat (gap) begin
            @(negedge clock);
            rsp_tready = 1'b0;
         end
         @(negedge clock);
         rsp_tready = 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         board.check_response(rsp_tdata, rsp_tuser);
         taken++;
      end
   end

   // offer one sample item after a random gap and wait for acceptance
   task automatic send_sample(logic [3:0] chan, logic [15:0] cur, logic [31:0] now,
                              logic on, logic locked);
      int gap;
      if (sent_total % 40 == 0) send_burst = ($urandom_range(0, 2) == 0);
      sent_total++;
      gap = send_burst ? 0 : $urandom_range(0, 12);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = chan;
      req_tdata  = {6'b0, locked, on, now, cur};
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_sample(chan, cur, now, on, locked);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      board.set_register(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // stop offering and wait until every response is back
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_phase(int p);
      logic [8:0]  w;
      logic [8:0]  t;
      logic [8:0]  s;
      logic [31:0] tmo;
      logic [15:0] nd;
      logic [15:0] ni;
      logic [15:0] ns;
      logic [3:0]  inr;
      case (p)
         0: begin
            w = 9'd110; t = 9'd140; s = 9'd170; tmo = 32'd60000;
            nd = 16'd2000; ni = 16'd2500; ns = 16'd3000; inr = 4'd3;
         end
         1: begin
            w = 9'd0; t = 9'd100; s = 9'd511; tmo = 32'd1;
            nd = 16'd0; ni = 16'd1; ns = 16'hFFFF; inr = 4'd1;
         end
         2: begin
            w = 9'd511; t = 9'd511; s = 9'd511; tmo = 32'hFFFF_FFFF;
            nd = 16'd12000; ni = 16'hFFFF; ns = 16'd12000; inr = 4'd15;
         end
         3: begin
            // timer start and timed trip on one sample, trip on first inrush sample
            w = 9'd110; t = 9'd140; s = 9'd170; tmo = 32'd0;
            nd = 16'd2000; ni = 16'd2500; ns = 16'd3000; inr = 4'd0;
         end
         4: begin
            // tiers out of order
            w = 9'd300; t = 9'd150; s = 9'd120; tmo = 32'd500;
            nd = 16'd2000; ni = 16'd1500; ns = 16'd2500; inr = 4'd2;
         end
         default: begin
            w   = 9'($urandom_range(100, 511));
            t   = 9'($urandom_range(100, 511));
            s   = 9'($urandom_range(100, 511));
            tmo = $urandom_range(1, 5000);
            nd  = 16'($urandom_range(200, 8000));
            ni  = 16'($urandom_range(200, 8000));
            ns  = 16'($urandom_range(200, 8000));
            inr = 4'($urandom_range(1, 15));
         end
      endcase
      write_register(REG_WARN_PCT, 32'(w));
      write_register(REG_TIMER_PCT, 32'(t));
      write_register(REG_INSTANT_PCT, 32'(s));
      write_register(REG_TIMEOUT, tmo);
      write_register(REG_NOM_DEF, 32'(nd));
      write_register(REG_NOM_INV, 32'(ni));
      write_register(REG_NOM_STR, 32'(ns));
      write_register(REG_INRUSH, 32'(inr));
   endtask

   // current a few mA around one tier of the channel, or anywhere
   function automatic logic [15:0] near_level(logic [3:0] chan, int tier);
      longint nom;
      longint pct;
      longint v;
      if (chan == INVERTER_INDEX_DEF)      nom = longint'(board.cfg.nom_inv_ma);
      else if (chan == STEERING_INDEX_DEF) nom = longint'(board.cfg.nom_str_ma);
      else                                 nom = longint'(board.cfg.nom_def_ma);
      case (tier)
         0: pct = longint'(board.cfg.warn_pct);
         1: pct = longint'(board.cfg.timer_pct);
         2: pct = longint'(board.cfg.instant_pct);
         default: return 16'($urandom());
      endcase
      v = nom * pct / 100 + longint'($urandom_range(0, 6)) - 3;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return 16'(v);
   endfunction

   // runs of samples on one channel at one tier, with some noise items
   task automatic random_phase(int items);
      int         sent;
      int         run_len;
      int         tier;
      int         k;
      int         pick;
      logic [3:0] chan;
      logic       on;
      logic       locked;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(0, 11);
         if (pick == 0)      chan = 4'($urandom_range(12, 15));
         else if (pick <= 2) chan = 4'(INVERTER_INDEX_DEF);
         else if (pick <= 4) chan = 4'(STEERING_INDEX_DEF);
         else                chan = 4'($urandom_range(0, 11));
         tier    = $urandom_range(0, 3);
         run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 18) : $urandom_range(1, 6);
         for (k = 0; k < run_len && sent < items; k++) begin
            if ($urandom_range(0, 9) == 0) begin
               send_sample(4'($urandom_range(0, 15)), 16'($urandom()), $urandom(),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
               ms_now = ms_now + $urandom_range(0, board.cfg.timeout_ms / 4 + 1);
               on     = ($urandom_range(0, 19) != 0);
               locked = ($urandom_range(0, 19) == 0);
               send_sample(chan, near_level(chan, tier), ms_now, on, locked);
            end
            sent++;
         end
      end
   endtask

   initial begin
      int p;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed samples at reset thresholds
      send_sample(4'd0, 16'd0, 32'd0, 1'b1, 1'b0);
      send_sample(4'd0, 16'd2201, 32'd10, 1'b1, 1'b0);
      send_sample(4'd0, 16'd2300, 32'd20, 1'b1, 1'b0);
      send_sample(4'd0, 16'd2800, 32'd100, 1'b1, 1'b0);
      send_sample(4'd0, 16'd2300, 32'd200, 1'b1, 1'b0);
      send_sample(4'd0, 16'd3000, 32'd60100, 1'b1, 1'b0);
      send_sample(4'd1, 16'd3401, 32'd60200, 1'b1, 1'b0);
      send_sample(4'd1, 16'd3400, 32'd60300, 1'b1, 1'b0);
      send_sample(4'd1, 16'd3400, 32'd60400, 1'b0, 1'b0);
      send_sample(4'd2, 16'hFFFF, 32'd60500, 1'b1, 1'b1);
      // inverter inrush: pending twice then trip, then counter cleared by a low sample
      send_sample(4'd9, 16'hFFFF, 32'd60600, 1'b1, 1'b0);
      send_sample(4'd9, 16'hFFFF, 32'd60610, 1'b1, 1'b0);
      send_sample(4'd9, 16'hFFFF, 32'd60620, 1'b1, 1'b0);
      send_sample(4'd9, 16'hFFFF, 32'd60630, 1'b1, 1'b0);
      send_sample(4'd9, 16'd100, 32'd60640, 1'b1, 1'b0);
      send_sample(4'd9, 16'hFFFF, 32'd60650, 1'b1, 1'b0);
      // steering inrush
      send_sample(4'd3, 16'hFFFF, 32'd60700, 1'b1, 1'b0);
      send_sample(4'd3, 16'hFFFF, 32'd60710, 1'b1, 1'b0);
      send_sample(4'd3, 16'hFFFF, 32'd60720, 1'b1, 1'b0);
      // channels out of range
      send_sample(4'd12, 16'hFFFF, 32'd60800, 1'b1, 1'b0);
      send_sample(4'd15, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      // timer across the millisecond wrap
      send_sample(4'd4, 16'd3000, 32'hFFFF_FF00, 1'b1, 1'b0);
      send_sample(4'd4, 16'd2500, 32'h0000_EA00, 1'b1, 1'b0);
      send_sample(4'd11, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      // exactly at warning level is still normal
      send_sample(4'd5, 16'd2200, 32'd70000, 1'b1, 1'b0);

      for (p = 0; p < PHASES; p++) begin
         settle();
         program_phase(p);
         random_phase(PHASE_ITEMS);
      end
      settle();
      repeat (8) @(posedge clock);

      if (board.mismatches == 0 && board.pending() == 0)
         $display("tiered_overcurrent_protection_core test passed");
      else
         $display("tiered_overcurrent_protection_core test failed");
      $finish;
   end

endmodule

/* sim.f */
rtl/otp_pkg.sv
rtl/otp_csr.sv
rtl/otp_scale.sv
rtl/otp_tier.sv
rtl/tiered_overcurrent_protection_core.sv
bench/tiered_overcurrent_protection_core_tb.sv
